// ----- sv/irt_pkg.sv -----
package irt_pkg;

    localparam int VALUE_W = 32;
    localparam int FIELD_W = 9;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_FULL      = 2'd1,
        ERR_UNWRITTEN = 2'd2
    } err_code_t;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] sample_value;
        logic [FIELD_W-1:0]        read_slot;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]        entry_rank;
        logic [FIELD_W-1:0]        entry_slot;
        logic signed [VALUE_W-1:0] entry_value;
        logic [1:0]                error_code;
    } out_item_t;

    // fixed-width part of the transaction that walks down the cell chain
    typedef struct packed {
        logic                      valid;
        logic                      is_read;
        err_code_t                 err;
        logic signed [VALUE_W-1:0] value;
        logic [FIELD_W-1:0]        slot;
    } pkt_t;

endpackage

// ----- sv/irt_stream_if.sv -----
interface irt_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/insertion_rank_table_unit.sv -----
// rank table built as a chain of TABLE_ENTRIES cells, one slot per cell. every
// transaction (insert or read) enters an issue register and then steps one cell
// per cycle while the chain advances; each cell compares its stored value with
// the passing insert value, bumps its own rank or adds to the running count,
// and the cell of the target slot stores the new entry or drops its contents
// into the transaction. a new transaction can be accepted in every cycle unless
// the chain holds, so the sustained rate is one per cycle. when a result waits
// at the end of the chain, the whole chain holds. inserts into a full table and
// reads of unwritten slots pass through with an error code and change nothing.
// slots are filled in order from zero.
module insertion_rank_table_unit #(
    parameter int TABLE_ENTRIES = 512
) (
    input logic          clk,
    input logic          rst_n,
    irt_stream_if.sink   request,
    irt_stream_if.source response
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int AW0   = (IDX_W > irt_pkg::FIELD_W) ? IDX_W : irt_pkg::FIELD_W;
    localparam int AW    = (CNT_W > AW0) ? CNT_W : AW0;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [AW-1:0]    count_wide;
    logic [AW-1:0]    slot_wide;
    logic             advance;
    logic             accept;
    logic             is_full;

    irt_pkg::pkt_t    issue_pkt_reg;
    irt_pkg::pkt_t    issue_pkt_next;
    logic [IDX_W-1:0] issue_tgt_reg;
    logic [IDX_W-1:0] issue_tgt_next;

    irt_pkg::pkt_t    pkt_chain [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] tgt_chain [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] cnt_chain [TABLE_ENTRIES+1];
    logic [AW-1:0]    rank_wide;

    assign advance       = !pkt_chain[TABLE_ENTRIES].valid || response.ready;
    assign request.ready = advance;
    assign accept        = request.valid && advance;

    assign count_wide = AW'(count_reg);
    assign slot_wide  = AW'(request.data.read_slot);
    assign is_full    = (count_reg == FULL_COUNT);

    always_comb
    begin
        issue_pkt_next         = '0;
        issue_pkt_next.valid   = request.valid;
        issue_pkt_next.is_read = (request.data.kind == irt_pkg::KIND_READ);
        issue_tgt_next         = count_wide[IDX_W-1:0];
        count_next             = count_reg;
        if (request.data.kind == irt_pkg::KIND_READ)
        begin
            issue_tgt_next      = slot_wide[IDX_W-1:0];
            issue_pkt_next.slot = request.data.read_slot;
            if (slot_wide >= count_wide)
            begin
                issue_pkt_next.err = irt_pkg::ERR_UNWRITTEN;
            end
            else
            begin
                issue_pkt_next.err = irt_pkg::ERR_OK;
            end
        end
        else if (is_full)
        begin
            issue_pkt_next.err = irt_pkg::ERR_FULL;
        end
        else
        begin
            issue_pkt_next.err   = irt_pkg::ERR_OK;
            issue_pkt_next.value = request.data.sample_value;
            issue_pkt_next.slot  = count_wide[irt_pkg::FIELD_W-1:0];
            if (accept)
            begin
                count_next = CNT_W'(count_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            issue_pkt_reg <= '0;
            issue_tgt_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (advance)
            begin
                issue_pkt_reg <= issue_pkt_next;
                issue_tgt_reg <= issue_tgt_next;
            end
        end
    end

    assign pkt_chain[0] = issue_pkt_reg;
    assign tgt_chain[0] = issue_tgt_reg;
    assign cnt_chain[0] = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        irt_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (advance),
            .pkt_in  (pkt_chain[i]),
            .tgt_in  (tgt_chain[i]),
            .cnt_in  (cnt_chain[i]),
            .pkt_out (pkt_chain[i+1]),
            .tgt_out (tgt_chain[i+1]),
            .cnt_out (cnt_chain[i+1])
        );
    end

    assign rank_wide = AW'(cnt_chain[TABLE_ENTRIES]);

    assign response.valid            = pkt_chain[TABLE_ENTRIES].valid;
    assign response.data.entry_rank  = rank_wide[irt_pkg::FIELD_W-1:0];
    assign response.data.entry_slot  = pkt_chain[TABLE_ENTRIES].slot;
    assign response.data.entry_value = pkt_chain[TABLE_ENTRIES].value;
    assign response.data.error_code  = pkt_chain[TABLE_ENTRIES].err;

`ifndef ASSERT_OFF
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond table size");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.data.kind == irt_pkg::KIND_INSERT && !is_full)
        |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("insert did not take a slot");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && request.data.kind == irt_pkg::KIND_INSERT) |=> $stable(count_reg))
        else $error("entry count changed without insert");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.data.error_code == irt_pkg::ERR_FULL)
        |-> (response.data.entry_rank == '0 && response.data.entry_value == '0
             && response.data.entry_slot == '0))
        else $error("full-table result carries data");

    a_ok_slot_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.data.error_code == irt_pkg::ERR_OK)
        |-> AW'(response.data.entry_slot) < count_wide)
        else $error("result from a slot that was never filled");
`endif

endmodule

// ----- sv/irt_cell.sv -----
module irt_cell #(
    parameter int IDX_W      = 9,
    parameter int CELL_INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  irt_pkg::pkt_t     pkt_in,
    input  logic [IDX_W-1:0]  tgt_in,
    input  logic [IDX_W-1:0]  cnt_in,
    output irt_pkg::pkt_t     pkt_out,
    output logic [IDX_W-1:0]  tgt_out,
    output logic [IDX_W-1:0]  cnt_out
);

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

    logic signed [irt_pkg::VALUE_W-1:0] value_reg;
    logic signed [irt_pkg::VALUE_W-1:0] value_next;
    logic [IDX_W-1:0]                   rank_reg;
    logic [IDX_W-1:0]                   rank_next;

    irt_pkg::pkt_t    pkt_reg;
    irt_pkg::pkt_t    pkt_next;
    logic [IDX_W-1:0] tgt_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;

    logic here;
    logic occupied;
    logic greater;

    // cells below the transaction's target slot hold live entries
    assign here     = (tgt_in == MY_INDEX);
    assign occupied = (MY_INDEX < tgt_in);
    assign greater  = (value_reg > pkt_in.value);

    always_comb
    begin
        pkt_next   = pkt_in;
        cnt_next   = cnt_in;
        value_next = value_reg;
        rank_next  = rank_reg;
        if (pkt_in.valid && pkt_in.err == irt_pkg::ERR_OK)
        begin
            if (!pkt_in.is_read)
            begin
                if (occupied)
                begin
                    if (greater)
                    begin
                        rank_next = IDX_W'(rank_reg + 1'b1);
                    end
                    else
                    begin
                        cnt_next = IDX_W'(cnt_in + 1'b1);
                    end
                end
                if (here)
                begin
                    // all earlier cells have counted by now, so the rank is final
                    value_next = pkt_in.value;
                    rank_next  = cnt_in;
                end
            end
            else if (here)
            begin
                pkt_next.value = value_reg;
                cnt_next       = rank_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg <= '0;
            tgt_reg <= '0;
            cnt_reg <= '0;
        end
        else if (en)
        begin
            pkt_reg <= pkt_next;
            tgt_reg <= tgt_in;
            cnt_reg <= cnt_next;
        end
    end

    assign pkt_out = pkt_reg;
    assign tgt_out = tgt_reg;
    assign cnt_out = cnt_reg;

endmodule
